// ===== hw/rtl/dtbp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtbp_pkg
// shared types and constants of the dial to bidirectional pwm block
// ----------------------------------------------------------------------------
`default_nettype none

package dtbp_pkg;

    localparam int PCT_W       = 7;
    localparam int TIME_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int OUT_DATA_W  = 48;
    localparam int PROD_W      = TIME_W + PCT_W;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;

    localparam logic [PCT_W-1:0]   FULL_PCT     = 7'd100;
    localparam logic [PCT_W-1:0]   SNAP_LOW     = 7'd5;
    localparam logic [PCT_W-1:0]   SNAP_HIGH    = 7'd95;
    localparam logic [TIME_W-1:0]  PERIOD_RESET = 16'd10000;
    // ceil(2^30 / 100), exact floor division for products below 2^23
    localparam logic [RECIP_W-1:0] RECIP_100    = 24'd10737419;

    // result word layout
    localparam int OUT_FWD_LSB   = 0;
    localparam int OUT_PCT_LSB   = 1;
    localparam int OUT_ON_LSB    = 8;
    localparam int OUT_OFF_LSB   = 24;
    localparam int OUT_FAULT_LSB = 40;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIAL_LOW  = 2'd0,
        CFG_DIAL_MID  = 2'd1,
        CFG_DIAL_HIGH = 2'd2,
        CFG_PERIOD_US = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic fwd;
        logic fault;
        logic force_zero;
        logic force_full;
    } dtbp_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dial_to_bidirectional_pwm_core.sv =====
// ----------------------------------------------------------------------------
// dial_to_bidirectional_pwm_core
// maps a dial sample to motor direction, duty percentage and pwm times
// ----------------------------------------------------------------------------
// usage
//   s_tvalid/s_tready/s_tdata carry one dial sample per request, the sample in
//   the low SAMPLE_BITS of s_tdata. m_tvalid/m_tready/m_tdata return one
//   result per sample, in order.
//   calibration (dial low, mid, high) and the pwm period are written through
//   cfg_we/cfg_addr/cfg_wdata while no request is in flight.
//   an accepted sample reaches m_tvalid through one set-up
//   stage, seven division cells (one quotient bit each) and two scaling
//   stages. every stage carries its own valid, so while the receiver does
//   not stall, a new sample is taken every cycle and throughput is one request per cycle.
//   when the receiver stalls, the output register holds its result and the
//   stages behind it fill up one by one; s_tready only falls once every
//   stage holds a request. empty stages close up while stalled.
//   reset clears all valids and loads the calibration defaults: low 0,
//   mid at half scale, high at full scale, period 10000 us.
// ----------------------------------------------------------------------------
`default_nettype none

module dial_to_bidirectional_pwm_core
    import dtbp_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [SAMPLE_BITS-1:0] dial_sample, rest zero
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] forward, [7:1] duty_percent, [23:8] on_time_us,
    // [39:24] off_time_us, [40] calib_fault, rest zero
    output logic [OUT_DATA_W-1:0]                m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]           cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]           cfg_wdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int REM_W  = SB + PCT_W;
    localparam int NCELLS = PCT_W;

    logic [SB-1:0]     dial_low_reg;
    logic [SB-1:0]     dial_mid_reg;
    logic [SB-1:0]     dial_high_reg;
    logic [TIME_W-1:0] period_us_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dial_low_reg  <= '0;
            dial_mid_reg  <= {1'b1, {(SB-1){1'b0}}};
            dial_high_reg <= '1;
            period_us_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_DIAL_LOW:  dial_low_reg  <= cfg_wdata[SB-1:0];
                CFG_DIAL_MID:  dial_mid_reg  <= cfg_wdata[SB-1:0];
                CFG_DIAL_HIGH: dial_high_reg <= cfg_wdata[SB-1:0];
                CFG_PERIOD_US: period_us_reg <= cfg_wdata[TIME_W-1:0];
                default:       ;
            endcase
        end
    end

    // links between stages: 0 is the set-up stage, NCELLS the last cell
    logic              link_valid [0:NCELLS];
    logic              link_ready [0:NCELLS];
    dtbp_flags_t       link_flags [0:NCELLS];
    logic [REM_W-1:0]  link_rem   [0:NCELLS];
    logic [SB-1:0]     link_span  [0:NCELLS];
    logic [PCT_W-1:0]  link_quo   [0:NCELLS];

    dtbp_prep #(
        .SB (SB)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sample    (s_tdata[SB-1:0]),
        .dial_low  (dial_low_reg),
        .dial_mid  (dial_mid_reg),
        .dial_high (dial_high_reg),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_flags (link_flags[0]),
        .out_rem   (link_rem[0]),
        .out_span  (link_span[0])
    );

    assign link_quo[0] = '0;

    genvar i;
    generate
        for (i = 0; i < NCELLS; i++)
        begin : g_cell
            dtbp_div_cell #(
                .SB  (SB),
                .BIT (NCELLS - 1 - i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (link_valid[i]),
                .in_ready  (link_ready[i]),
                .in_flags  (link_flags[i]),
                .in_rem    (link_rem[i]),
                .in_span   (link_span[i]),
                .in_quo    (link_quo[i]),
                .out_valid (link_valid[i+1]),
                .out_ready (link_ready[i+1]),
                .out_flags (link_flags[i+1]),
                .out_rem   (link_rem[i+1]),
                .out_span  (link_span[i+1]),
                .out_quo   (link_quo[i+1])
            );
        end
    endgenerate

    dtbp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[NCELLS]),
        .in_ready  (link_ready[NCELLS]),
        .in_flags  (link_flags[NCELLS]),
        .in_quo    (link_quo[NCELLS]),
        .period_us (period_us_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/dtbp_prep.sv =====
// ----------------------------------------------------------------------------
// dtbp_prep
// picks direction, distance from mid and span, flags the special spans
// ----------------------------------------------------------------------------
`default_nettype none

module dtbp_prep
    import dtbp_pkg::*;
#(
    parameter int SB = 10
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [SB-1:0]     sample,
    input  wire logic [SB-1:0]     dial_low,
    input  wire logic [SB-1:0]     dial_mid,
    input  wire logic [SB-1:0]     dial_high,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dtbp_flags_t            out_flags,
    output logic [SB+PCT_W-1:0]    out_rem,
    output logic [SB-1:0]          out_span
);

    localparam int REM_W = SB + PCT_W;

    logic               valid_reg;
    dtbp_flags_t        flags_reg, flags_next;
    logic [REM_W-1:0]   rem_reg;
    logic [SB-1:0]      span_reg;

    logic               hi_gt_lo;
    logic               upper_side;
    logic [SB-1:0]      num;
    logic [SB-1:0]      span_a;
    logic [SB-1:0]      span_b;
    logic [SB:0]        span_diff;
    logic [REM_W-1:0]   dividend;
    logic               ovf;

    always_comb
    begin
        hi_gt_lo = dial_high > dial_low;
        if (hi_gt_lo)
        begin
            upper_side = sample >= dial_mid;
            span_a     = upper_side ? dial_high : dial_mid;
            span_b     = upper_side ? dial_mid  : dial_low;
        end
        else
        begin
            upper_side = sample > dial_mid;
            span_a     = upper_side ? dial_low : dial_mid;
            span_b     = upper_side ? dial_mid : dial_high;
        end
        num       = upper_side ? (sample - dial_mid) : (dial_mid - sample);
        span_diff = {1'b0, span_a} - {1'b0, span_b};
        dividend  = {{PCT_W{1'b0}}, num} * {{SB{1'b0}}, FULL_PCT};
        // quotient would not fit seven bits: saturates to full anyway
        ovf       = dividend >= {span_diff[SB-1:0], {PCT_W{1'b0}}};

        // forward when the sample is on the low side of a normal dial,
        // or on the high side of a mirrored one
        flags_next.fwd        = hi_gt_lo ? !upper_side : upper_side;
        flags_next.fault      = span_diff == '0;
        flags_next.force_zero = span_diff[SB];
        flags_next.force_full = !span_diff[SB] && ovf;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            flags_reg <= flags_next;
            rem_reg   <= dividend;
            span_reg  <= span_diff[SB-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign out_rem   = rem_reg;
    assign out_span  = span_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dtbp_div_cell.sv =====
// ----------------------------------------------------------------------------
// dtbp_div_cell
// one restoring division step, resolves a single quotient bit per request
// ----------------------------------------------------------------------------
`default_nettype none

module dtbp_div_cell
    import dtbp_pkg::*;
#(
    parameter int SB  = 10,
    parameter int BIT = 6
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dtbp_flags_t       in_flags,
    input  wire logic [SB+PCT_W-1:0] in_rem,
    input  wire logic [SB-1:0]     in_span,
    input  wire logic [PCT_W-1:0]  in_quo,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dtbp_flags_t            out_flags,
    output logic [SB+PCT_W-1:0]    out_rem,
    output logic [SB-1:0]          out_span,
    output logic [PCT_W-1:0]       out_quo
);

    localparam int REM_W = SB + PCT_W;

    logic               valid_reg;
    dtbp_flags_t        flags_reg;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [SB-1:0]      span_reg;
    logic [PCT_W-1:0]   quo_reg, quo_next;

    logic [REM_W-1:0]   trial;
    logic               take;

    always_comb
    begin
        trial    = {{PCT_W{1'b0}}, in_span} << BIT;
        take     = in_rem >= trial;
        rem_next = take ? (in_rem - trial) : in_rem;
        quo_next = in_quo;
        quo_next[BIT] = take;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            flags_reg <= in_flags;
            rem_reg   <= rem_next;
            span_reg  <= in_span;
            quo_reg   <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign out_rem   = rem_reg;
    assign out_span  = span_reg;
    assign out_quo   = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dtbp_scale.sv =====
// ----------------------------------------------------------------------------
// dtbp_scale
// deadband snapping, on and off times, output register
// ----------------------------------------------------------------------------
`default_nettype none

module dtbp_scale
    import dtbp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire dtbp_flags_t           in_flags,
    input  wire logic [PCT_W-1:0]      in_quo,
    input  wire logic [TIME_W-1:0]     period_us,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    // product stage
    logic               prod_valid_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PCT_W-1:0]   pct_reg, pct_next;
    logic               fwd_reg;
    logic               fault_reg;
    logic               prod_ready;

    // output stage
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  tdata_reg, tdata_next;

    logic [PROD_W+RECIP_W-1:0] on_wide;
    logic [TIME_W-1:0]         on_time;
    logic [TIME_W-1:0]         off_time;

    always_comb
    begin
        if (in_flags.force_zero)
            pct_next = '0;
        else if (in_flags.force_full)
            pct_next = FULL_PCT;
        else if (in_quo <= SNAP_LOW)
            pct_next = '0;
        else if (in_quo >= SNAP_HIGH)
            pct_next = FULL_PCT;
        else
            pct_next = in_quo;
    end

    assign prod_ready = !out_valid_reg || m_tready;
    assign in_ready   = !prod_valid_reg || prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg  <= {{PCT_W{1'b0}}, period_us} * {{TIME_W{1'b0}}, pct_next};
            pct_reg   <= pct_next;
            fwd_reg   <= in_flags.fwd;
            fault_reg <= in_flags.fault;
        end
    end

    // divide by 100 through the reciprocal
    always_comb
    begin
        on_wide  = {{RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RECIP_100};
        on_time  = on_wide[RECIP_SHIFT +: TIME_W];
        off_time = period_us - on_time;

        tdata_next = '0;
        tdata_next[OUT_FWD_LSB]            = fwd_reg;
        tdata_next[OUT_PCT_LSB +: PCT_W]   = pct_reg;
        tdata_next[OUT_ON_LSB +: TIME_W]   = on_time;
        tdata_next[OUT_OFF_LSB +: TIME_W]  = off_time;
        tdata_next[OUT_FAULT_LSB]          = fault_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && prod_valid_reg)
        begin
            tdata_reg <= tdata_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dtbp_checker.sv =====
// ----------------------------------------------------------------------------
// dtbp_checker
// port-level checks of the dial to bidirectional pwm block
// ----------------------------------------------------------------------------
`default_nettype none

module dtbp_checker
    import dtbp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata
);

    logic [PCT_W-1:0]  duty;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_time;

    assign duty     = m_tdata[OUT_PCT_LSB +: PCT_W];
    assign on_time  = m_tdata[OUT_ON_LSB +: TIME_W];
    assign off_time = m_tdata[OUT_OFF_LSB +: TIME_W];

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // duty is either zero or past the deadband, and never above full
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (duty == '0) || (duty > SNAP_LOW && duty <= FULL_PCT))
        else $error("duty outside snapped range");

    // zero duty gives no on time, full duty gives no off time
    a_duty_times: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (duty != '0 || on_time == '0) &&
                     (duty != FULL_PCT || off_time == '0))
        else $error("on or off time inconsistent with duty");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind dial_to_bidirectional_pwm_core dtbp_checker u_dtbp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
